>>> hw/rtl/efd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efd_pkg
// shared types and constants for the escaped frame decoder
// ----------------------------------------------------------------------------
package efd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned PHASE_W = 3;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [PHASE_W-1:0] phase_t;

    localparam phase_t PH_IDLE    = 3'd0;
    localparam phase_t PH_LEN     = 3'd1;
    localparam phase_t PH_LEN_ESC = 3'd2;
    localparam phase_t PH_DATA    = 3'd3;
    localparam phase_t PH_SUM     = 3'd4;
    localparam phase_t PH_SUM_ESC = 3'd5;

    localparam kind_t K_TYPE    = 3'd0;
    localparam kind_t K_PAYLOAD = 3'd1;
    localparam kind_t K_GOOD    = 3'd2;
    localparam kind_t K_BADSUM  = 3'd3;
    localparam kind_t K_ZEROLEN = 3'd4;

    localparam byte_t XOR_MASK     = 8'h20;
    localparam byte_t SUM_GOOD     = 8'hFF;
    localparam byte_t START_RESET  = 8'd126;
    localparam byte_t ESCAPE_RESET = 8'd125;

    localparam logic CFG_START  = 1'b0;
    localparam logic CFG_ESCAPE = 1'b1;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        byte_t value;
        byte_t position;
    } result_t;

endpackage : efd_pkg
`default_nettype wire

>>> hw/rtl/escaped_frame_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_frame_decoder_unit
// byte-stuffed frame decoder with an additive checksum
//
// one received byte per s_ transaction on s_tdata. a start byte restarts
// framing at any point; the next byte is the length (type plus payload),
// followed by type, payload and a checksum byte. an escape byte is dropped and
// the byte after it is taken xor 0x20. each decoded type or payload byte and
// the final good, bad-checksum or zero-length verdict leave as one m_
// transaction; start, escape, nonzero length and idle bytes produce none.
// the kind travels on m_tuser, value and position on m_tdata.
// each accepted byte goes into the input register, through the combinational
// decode and into the result register that drives m_tvalid. throughput: one
// byte per cycle while the result register can advance; s_tready stays high
// while m_tready is high or the result register is empty.
// a stalled receiver holds the result register, and the input register then
// holds one more byte before s_tready drops.
// synchronous active-low reset returns to waiting for start, empties both
// registers and loads start 0x7e and escape 0x7d. configuration writes via
// cfg_wen / cfg_index / cfg_wdata take effect at once; the user must make
// them only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module escaped_frame_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] value, [15:8] position
    output logic [2:0]       m_tuser    // [2:0] kind
);

    efd_pkg::byte_t  start_reg, escape_reg;
    efd_pkg::byte_t  in_byte_reg;
    logic            in_valid_reg;

    efd_pkg::phase_t phase_reg, phase_next;
    logic            esc_reg, esc_next;
    efd_pkg::byte_t  count_reg, count_next;
    efd_pkg::byte_t  flen_reg, flen_next;
    efd_pkg::byte_t  sum_reg, sum_next;

    efd_pkg::result_t res;
    logic             out_valid_reg;
    efd_pkg::kind_t   out_kind_reg;
    efd_pkg::byte_t   out_value_reg, out_pos_reg;

    logic            advance;
    efd_pkg::byte_t  b, bx, dsum, count_inc;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_value_reg};
    assign m_tuser  = out_kind_reg;

    always_comb begin
        b          = in_byte_reg;
        bx         = b ^ efd_pkg::XOR_MASK;
        phase_next = phase_reg;
        esc_next   = esc_reg;
        count_next = count_reg;
        flen_next  = flen_reg;
        sum_next   = sum_reg;
        res        = '0;
        count_inc  = count_reg + 8'd1;
        dsum       = '0;
        if (b == start_reg) begin
            esc_next   = 1'b0;
            count_next = '0;
            sum_next   = '0;
            phase_next = efd_pkg::PH_LEN;
        end else begin
            case (phase_reg)
                efd_pkg::PH_LEN, efd_pkg::PH_LEN_ESC: begin
                    if (phase_reg == efd_pkg::PH_LEN && b == escape_reg) begin
                        phase_next = efd_pkg::PH_LEN_ESC;
                    end else begin
                        dsum      = (phase_reg == efd_pkg::PH_LEN_ESC) ? bx : b;
                        flen_next = dsum;
                        if (dsum == 8'd0) begin
                            phase_next = efd_pkg::PH_IDLE;
                            res.valid  = 1'b1;
                            res.kind   = efd_pkg::K_ZEROLEN;
                        end else begin
                            phase_next = efd_pkg::PH_DATA;
                        end
                    end
                end
                efd_pkg::PH_DATA: begin
                    if (!esc_reg && b == escape_reg) begin
                        esc_next = 1'b1;
                    end else begin
                        esc_next   = 1'b0;
                        dsum       = esc_reg ? bx : b;
                        sum_next   = sum_reg + dsum;
                        count_next = count_inc;
                        res.valid  = 1'b1;
                        res.value  = dsum;
                        if (count_reg == 8'd0) begin
                            res.kind = efd_pkg::K_TYPE;
                        end else begin
                            res.kind     = efd_pkg::K_PAYLOAD;
                            res.position = count_reg - 8'd1;
                        end
                        if (count_inc == flen_reg) begin
                            phase_next = efd_pkg::PH_SUM;
                        end
                    end
                end
                efd_pkg::PH_SUM, efd_pkg::PH_SUM_ESC: begin
                    if (phase_reg == efd_pkg::PH_SUM && b == escape_reg) begin
                        phase_next = efd_pkg::PH_SUM_ESC;
                    end else begin
                        dsum       = (phase_reg == efd_pkg::PH_SUM_ESC) ? bx : b;
                        sum_next   = sum_reg + dsum;
                        phase_next = efd_pkg::PH_IDLE;
                        res.valid  = 1'b1;
                        if (sum_next == efd_pkg::SUM_GOOD) begin
                            res.kind  = efd_pkg::K_GOOD;
                            res.value = flen_reg - 8'd1;
                        end else begin
                            res.kind  = efd_pkg::K_BADSUM;
                        end
                    end
                end
                default: begin
                    phase_next = efd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg     <= efd_pkg::START_RESET;
            escape_reg    <= efd_pkg::ESCAPE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= efd_pkg::PH_IDLE;
            esc_reg       <= 1'b0;
            count_reg     <= '0;
            flen_reg      <= '0;
            sum_reg       <= '0;
        end else begin
            if (cfg_wen) begin
                if (cfg_index == efd_pkg::CFG_START) begin
                    start_reg <= cfg_wdata;
                end else begin
                    escape_reg <= cfg_wdata;
                end
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg && res.valid;
            end
            if (in_valid_reg && advance) begin
                phase_reg <= phase_next;
                esc_reg   <= esc_next;
                count_reg <= count_next;
                flen_reg  <= flen_next;
                sum_reg   <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && in_valid_reg && res.valid) begin
            out_kind_reg  <= res.kind;
            out_value_reg <= res.value;
            out_pos_reg   <= res.position;
        end
    end

endmodule : escaped_frame_decoder_unit
`default_nettype wire

>>> tb/sv/escaped_frame_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// escaped_frame_decoder_unit_tb
// self-checking bench for the byte-stuffed frame decoder
//
// a queue-fed driver sends received bytes on the s_ stream with random gaps.
// a clocked monitor decodes every accepted byte in a local copy of the
// decoder and checks each m_ transaction, in order, against the oldest
// expected result. a short directed sequence covers escapes, restarts and
// zero lengths. the random part then sends mostly well-formed stuffed frames
// with random content, plus bad checksums, cut-off frames and noise, under
// several start and escape settings including the extremes. a watchdog ends
// the run if traffic stops.
// ----------------------------------------------------------------------------
module escaped_frame_decoder_unit_tb;

    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned PHASES      = 7;
    localparam int unsigned PHASE_ITEMS = 180;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic        cfg_index = efd_pkg::CFG_START;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    escaped_frame_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    efd_pkg::byte_t   pending_bytes[$];
    efd_pkg::result_t expected_results[$];
    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned error_count    = 0;
    int unsigned stall_cycles   = 0;
    int unsigned gap_left       = 0;
    int unsigned ready_hold     = 0;
    bit          quiet          = 1'b0;
    bit          s_taken        = 1'b0;
    bit          m_taken        = 1'b0;

    // local copy of the decoder registers and framing state
    efd_pkg::byte_t  cur_start   = efd_pkg::START_RESET;
    efd_pkg::byte_t  cur_escape  = efd_pkg::ESCAPE_RESET;
    efd_pkg::phase_t frame_phase = efd_pkg::PH_IDLE;
    bit              esc_armed   = 1'b0;
    efd_pkg::byte_t  data_count  = 8'd0;
    efd_pkg::byte_t  frame_len   = 8'd0;
    efd_pkg::byte_t  sum_acc     = 8'd0;

    efd_pkg::byte_t directed_seq [0:25] = '{
        8'h00,
        8'h7E, 8'h00,
        8'h7E, 8'h7D, 8'h20,
        8'h7E, 8'h7D, 8'h22, 8'h7D, 8'h5D, 8'h7D, 8'h7D, 8'h25,
        8'h7E, 8'h03, 8'h7D, 8'h7E, 8'h01, 8'hFF, 8'h00,
        8'h7E, 8'h01, 8'h41, 8'h7D, 8'h00
    };

    efd_pkg::byte_t start_set  [0:PHASES-1] =
        '{8'h00, 8'hFF, 8'h7D, 8'hAA, 8'h20, 8'h00, efd_pkg::START_RESET};
    efd_pkg::byte_t escape_set [0:PHASES-1] =
        '{8'hFF, 8'h00, 8'h7E, 8'hAA, 8'h20, 8'h00, efd_pkg::ESCAPE_RESET};

    function automatic efd_pkg::result_t take_len(input efd_pkg::byte_t n);
        efd_pkg::result_t r;
        r = '0;
        frame_len = n;
        if (n == 8'd0) begin
            frame_phase = efd_pkg::PH_IDLE;
            r.valid = 1'b1;
            r.kind  = efd_pkg::K_ZEROLEN;
        end else begin
            frame_phase = efd_pkg::PH_DATA;
        end
        return r;
    endfunction

    function automatic efd_pkg::result_t take_data(input efd_pkg::byte_t d);
        efd_pkg::result_t r;
        r = '0;
        sum_acc = sum_acc + d;
        r.valid = 1'b1;
        r.value = d;
        if (data_count == 8'd0) begin
            r.kind = efd_pkg::K_TYPE;
        end else begin
            r.kind     = efd_pkg::K_PAYLOAD;
            r.position = data_count - 8'd1;
        end
        data_count = data_count + 8'd1;
        if (data_count == frame_len) frame_phase = efd_pkg::PH_SUM;
        return r;
    endfunction

    function automatic efd_pkg::result_t take_sum(input efd_pkg::byte_t d);
        efd_pkg::result_t r;
        r = '0;
        sum_acc     = sum_acc + d;
        frame_phase = efd_pkg::PH_IDLE;
        r.valid     = 1'b1;
        if (sum_acc == efd_pkg::SUM_GOOD) begin
            r.kind  = efd_pkg::K_GOOD;
            r.value = frame_len - 8'd1;
        end else begin
            r.kind = efd_pkg::K_BADSUM;
        end
        return r;
    endfunction

    function automatic efd_pkg::result_t decode_byte(input efd_pkg::byte_t b);
        efd_pkg::result_t r;
        r = '0;
        if (b == cur_start) begin
            esc_armed   = 1'b0;
            data_count  = 8'd0;
            sum_acc     = 8'd0;
            frame_phase = efd_pkg::PH_LEN;
            return r;
        end
        case (frame_phase)
            efd_pkg::PH_LEN: begin
                if (b == cur_escape) frame_phase = efd_pkg::PH_LEN_ESC;
                else r = take_len(b);
            end
            efd_pkg::PH_LEN_ESC: r = take_len(b ^ efd_pkg::XOR_MASK);
            efd_pkg::PH_DATA: begin
                if (esc_armed) begin
                    esc_armed = 1'b0;
                    r = take_data(b ^ efd_pkg::XOR_MASK);
                end else if (b == cur_escape) begin
                    esc_armed = 1'b1;
                end else begin
                    r = take_data(b);
                end
            end
            efd_pkg::PH_SUM: begin
                if (b == cur_escape) frame_phase = efd_pkg::PH_SUM_ESC;
                else r = take_sum(b);
            end
            efd_pkg::PH_SUM_ESC: r = take_sum(b ^ efd_pkg::XOR_MASK);
            default: frame_phase = efd_pkg::PH_IDLE;
        endcase
        return r;
    endfunction

    // byte source
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left = gap_left - 1;
            end else if (pending_bytes.size() != 0) begin
                s_tdata  <= pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                gap_left = quiet ? 0 : $urandom_range(0, 3);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink back-pressure
    always @(negedge aclk) begin
        if (m_taken) ready_hold = quiet ? 0 : $urandom_range(0, 3);
        if (ready_hold != 0) begin
            m_tready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge aclk) begin
        s_taken <= aresetn && s_tvalid && s_tready;
        m_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected result: expected none, got kind %0d value %0d ",
                             $time, m_tuser, m_tdata[7:0], "position %0d", m_tdata[15:8]);
                end else begin
                    efd_pkg::result_t want;
                    want = expected_results.pop_front();
                    if (want.kind != m_tuser || want.value != m_tdata[7:0]
                            || want.position != m_tdata[15:8]) begin
                        error_count++;
                        $display("%0t mismatch: expected kind %0d value %0d position %0d, ",
                                 $time, want.kind, want.value, want.position,
                                 "got kind %0d value %0d position %0d",
                                 m_tuser, m_tdata[7:0], m_tdata[15:8]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                efd_pkg::result_t got;
                got = decode_byte(s_tdata);
                if (got.valid) expected_results.push_back(got);
                bytes_accepted++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic push_byte(input efd_pkg::byte_t b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // stuff clashing bytes and some others, unless escape or d^0x20 is start
    task automatic push_coded(input efd_pkg::byte_t d);
        if ((d == cur_start || d == cur_escape || $urandom_range(0, 7) == 0)
                && cur_escape != cur_start && (d ^ efd_pkg::XOR_MASK) != cur_start) begin
            push_byte(cur_escape);
            push_byte(d ^ efd_pkg::XOR_MASK);
        end else begin
            push_byte(d);
        end
    endtask

    function automatic efd_pkg::byte_t pick_data();
        case ($urandom_range(0, 11))
            0: return cur_start;
            1: return cur_escape;
            2: return cur_escape ^ efd_pkg::XOR_MASK;
            3: return cur_start ^ efd_pkg::XOR_MASK;
            default: return efd_pkg::byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_frame(input int len, input bit good);
        efd_pkg::byte_t sum;
        efd_pkg::byte_t d;
        sum = 8'd0;
        push_byte(cur_start);
        push_coded(efd_pkg::byte_t'(len));
        for (int i = 0; i < len; i++) begin
            d = pick_data();
            sum = sum + d;
            push_coded(d);
        end
        sum = efd_pkg::SUM_GOOD - sum;
        if (!good) sum = sum + efd_pkg::byte_t'($urandom_range(1, 255));
        push_coded(sum);
    endtask

    // leave the decoder waiting for start through a zero-length frame
    task automatic queue_close();
        push_byte(cur_start);
        if (cur_start != 8'd0 && cur_escape != 8'd0) begin
            push_byte(8'd0);
        end else begin
            push_byte(cur_escape);
            push_byte(efd_pkg::XOR_MASK);
        end
    endtask

    task automatic settle_decoder();
        while (bytes_accepted != bytes_queued || expected_results.size() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input efd_pkg::byte_t val);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == efd_pkg::CFG_START) cur_start = val;
        else cur_escape = val;
    endtask

    initial begin
        int unsigned done;
        int unsigned mark;
        int unsigned pick;
        efd_pkg::byte_t rs;
        efd_pkg::byte_t re;
        do begin
            rs = efd_pkg::byte_t'($urandom_range(0, 255));
            re = efd_pkg::byte_t'($urandom_range(0, 255));
        end while (!((rs != 8'd0 && re != 8'd0) || (re != rs && rs != efd_pkg::XOR_MASK)));
        start_set[5]  = rs;
        escape_set[5] = re;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_seq[i]) push_byte(directed_seq[i]);

        for (int p = 0; p < PHASES; p++) begin
            settle_decoder();
            quiet = (p % 3 == 1);
            write_reg(efd_pkg::CFG_START, start_set[p]);
            write_reg(efd_pkg::CFG_ESCAPE, escape_set[p]);
            @(negedge aclk);
            cfg_wen <= 1'b0;
            if (p == 0 || p == PHASES - 1) queue_frame(255, 1'b1);
            done = 0;
            while (done < PHASE_ITEMS) begin
                mark = bytes_queued;
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    queue_frame(($urandom_range(0, 39) == 0) ? $urandom_range(9, 255)
                                                             : $urandom_range(1, 8),
                                pick < 65);
                    done += bytes_queued - mark;
                end else if (pick < 88) begin
                    push_byte(cur_start);
                    repeat ($urandom_range(1, 6))
                        push_byte(efd_pkg::byte_t'($urandom_range(0, 255)));
                    done += bytes_queued - mark;
                end else if (pick < 93) begin
                    queue_close();
                    done += bytes_queued - mark;
                end else begin
                    repeat ($urandom_range(1, 4))
                        push_byte(efd_pkg::byte_t'($urandom_range(0, 255)));
                end
            end
            queue_close();
        end

        settle_decoder();
        if (expected_results.size() != 0) begin
            error_count++;
            $display("%0t %0d expected results never arrived", $time, expected_results.size());
        end
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule : escaped_frame_decoder_unit_tb

>>> sim.f
hw/rtl/efd_pkg.sv
hw/rtl/escaped_frame_decoder_unit.sv
tb/sv/escaped_frame_decoder_unit_tb.sv
